// File: design/mptt_pkg.sv
// ----------------------------------------------------------------------------
// mptt_pkg
// Shared types and constants of the multi-channel pulse/toggle timer.
// ----------------------------------------------------------------------------
package mptt_pkg;

  // field widths
  localparam int ACT_W   = 3;
  localparam int CHAN_W  = 5;
  localparam int MS_W    = 16;
  localparam int STAT_W  = 2;
  localparam int BANK_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [ACT_W-1:0]      action_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [STAT_W-1:0]     status_t;
  typedef logic [BANK_W-1:0]     bank_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // action codes
  localparam action_t ACT_TRIGGER = 3'd0;
  localparam action_t ACT_TOGGLE  = 3'd1;
  localparam action_t ACT_CLEAR   = 3'd2;
  localparam action_t ACT_TICK    = 3'd3;
  localparam action_t ACT_STATUS  = 3'd4;

  // status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_CHAN  = 2'd1;
  localparam status_t ST_BEYOND   = 2'd2;
  localparam status_t ST_RUNNING  = 2'd3;

  // register indexes
  localparam cfg_idx_t REG_CHANNEL_COUNT  = 2'd0;
  localparam cfg_idx_t REG_INITIAL_LEVELS = 2'd1;
  localparam cfg_idx_t REG_DEFAULT_PULSE  = 2'd2;

  // register reset values
  localparam chan_t COUNT_RESET         = 5'd16;
  localparam bank_t INITIAL_LEVELS_RESET = 16'd0;
  localparam ms_t   DEFAULT_PULSE_RESET  = 16'd200;

endpackage

// File: design/mptt_in_if.sv
// ----------------------------------------------------------------------------
// mptt_in_if
// Command channel of the pulse timer: valid/ready plus the command word.
// ----------------------------------------------------------------------------
interface mptt_in_if;
  logic              valid;
  logic              ready;
  mptt_pkg::action_t action;
  mptt_pkg::chan_t   channel;
  logic              invert;
  mptt_pkg::ms_t     pulse_ms;
  mptt_pkg::ms_t     elapsed_ms;

  modport source (output valid, action, channel, invert, pulse_ms, elapsed_ms,
                  input ready);
  modport sink   (input valid, action, channel, invert, pulse_ms, elapsed_ms,
                  output ready);
endinterface

// File: design/mptt_out_if.sv
// ----------------------------------------------------------------------------
// mptt_out_if
// Result channel of the pulse timer: valid/ready plus the result word.
// ----------------------------------------------------------------------------
interface mptt_out_if;
  logic              valid;
  logic              ready;
  mptt_pkg::status_t status;
  mptt_pkg::chan_t   channel_echo;
  logic              level;
  mptt_pkg::ms_t     pulse_len;
  mptt_pkg::bank_t   levels;
  mptt_pkg::bank_t   running_mask;

  modport source (output valid, status, channel_echo, level, pulse_len, levels,
                  running_mask, input ready);
  modport sink   (input valid, status, channel_echo, level, pulse_len, levels,
                  running_mask, output ready);
endinterface

// File: design/multi_channel_pulse_toggle_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_toggle_timer
// Bank of output bits, each with a one-shot millisecond countdown kept in RAM.
// ----------------------------------------------------------------------------
// Timing: trigger, toggle, clear and status give their result word in the cycle
//   after acceptance; tick walks n = min(channel_count, CHANNELS) countdown RAM
//   entries, one entry read-modify-written per cycle, then gives its result word.
// Throughput: one word per cycle for non-tick actions while results are taken; no new word during a tick walk.
// Reset (rst_n low, synchronous): no pulse running, levels 0, channel count 16,
//   default pulse 200; countdown RAM needs no clearing, running bits guard it.
module multi_channel_pulse_toggle_timer #(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mptt_in_if.sink               in_if,
  mptt_out_if.source            out_if,
  input  logic                  cfg_wr_en,
  input  mptt_pkg::cfg_idx_t    cfg_index,
  input  mptt_pkg::cfg_data_t   cfg_data
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);
  localparam int LW = (CHANNELS > mptt_pkg::BANK_W) ? CHANNELS : mptt_pkg::BANK_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                 state_r, state_nxt;
  mptt_pkg::chan_t      count_r, count_nxt;
  mptt_pkg::ms_t        default_r, default_nxt;
  logic [LW-1:0]        levels_r, levels_nxt;
  logic [CHANNELS-1:0]  running_r, running_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]        stg_idx_r, stg_idx_nxt;
  mptt_pkg::ms_t        elapsed_r, elapsed_nxt;

  logic                 out_valid_r, out_valid_nxt;
  mptt_pkg::status_t    out_status_r;
  mptt_pkg::chan_t      out_echo_r;
  logic                 out_level_r;
  mptt_pkg::ms_t        out_len_r;
  mptt_pkg::bank_t      out_levels_r;
  mptt_pkg::bank_t      out_running_r;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  mptt_pkg::ms_t        ram_wdata;
  logic [IW-1:0]        ram_raddr;
  mptt_pkg::ms_t        ram_rdata;

  logic [CW-1:0]        live_n;
  logic                 acc;
  logic [IW-1:0]        chan_idx;
  logic                 load;
  mptt_pkg::status_t    res_status;
  mptt_pkg::chan_t      res_echo;
  logic                 res_level;
  mptt_pkg::ms_t        res_len;
  logic [LW-1:0]        run_pad;

  // countdown store
  mptt_ram #(
    .WIDTH (mptt_pkg::MS_W),
    .DEPTH (CHANNELS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective channel count
  always_comb begin
    if (32'(count_r) < CHANNELS) begin
      live_n = CW'(count_r);
    end else begin
      live_n = CW'(CHANNELS);
    end
  end

  // handshake
  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign acc         = in_if.valid && in_if.ready;
  assign chan_idx    = IW'(32'(in_if.channel) - 32'd1);

  // action decode and tick walk
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    default_nxt = default_r;
    levels_nxt  = levels_r;
    running_nxt = running_r;
    rd_idx_nxt  = rd_idx_r;
    stg_idx_nxt = stg_idx_r;
    elapsed_nxt = elapsed_r;
    ram_we      = 1'b0;
    ram_waddr   = stg_idx_r;
    ram_wdata   = ram_rdata - elapsed_r;
    ram_raddr   = '0;
    load        = 1'b0;
    res_status  = mptt_pkg::ST_OK;
    res_echo    = '0;
    res_level   = 1'b0;
    res_len     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          load = 1'b1;
          unique case (in_if.action)
            mptt_pkg::ACT_TRIGGER, mptt_pkg::ACT_TOGGLE: begin
              res_echo = in_if.channel;
              if (in_if.channel == '0) begin
                res_status = mptt_pkg::ST_NO_CHAN;
              end else if (32'(in_if.channel) > 32'(live_n)) begin
                res_status = mptt_pkg::ST_BEYOND;
              end else if (running_r[chan_idx]) begin
                res_status = mptt_pkg::ST_RUNNING;
              end else if (in_if.action == mptt_pkg::ACT_TRIGGER) begin
                res_level            = !in_if.invert;
                levels_nxt[chan_idx] = !in_if.invert;
                res_len = (in_if.pulse_ms != '0) ? in_if.pulse_ms : default_r;
                ram_we    = 1'b1;
                ram_waddr = chan_idx;
                ram_wdata = res_len;
                running_nxt[chan_idx] = (res_len != '0);
              end else begin
                res_level            = !levels_r[chan_idx];
                levels_nxt[chan_idx] = !levels_r[chan_idx];
              end
            end
            mptt_pkg::ACT_CLEAR: begin
              for (int i = 0; i < CHANNELS; i++) begin
                if ((i < 32'(live_n)) && running_r[i]) begin
                  levels_nxt[i]  = !levels_r[i];
                  running_nxt[i] = 1'b0;
                end
              end
            end
            mptt_pkg::ACT_TICK: begin
              if (live_n != '0) begin
                // start walk: read entry 0 now, process it next cycle
                load        = 1'b0;
                state_nxt   = ST_TICK;
                ram_raddr   = '0;
                stg_idx_nxt = '0;
                rd_idx_nxt  = CW'(1);
                elapsed_nxt = in_if.elapsed_ms;
              end
            end
            default: begin
              // status and unused codes only report
            end
          endcase
        end
      end
      ST_TICK: begin
        // update the entry read last cycle
        if (running_r[stg_idx_r]) begin
          if (ram_rdata <= elapsed_r) begin
            running_nxt[stg_idx_r] = 1'b0;
            levels_nxt[stg_idx_r]  = !levels_r[stg_idx_r];
          end else begin
            ram_we = 1'b1;
          end
        end
        // issue the next read or finish
        if (rd_idx_r < live_n) begin
          ram_raddr   = IW'(rd_idx_r);
          stg_idx_nxt = IW'(rd_idx_r);
          rd_idx_nxt  = CW'(rd_idx_r + 1'b1);
        end else begin
          state_nxt = ST_IDLE;
          load      = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        mptt_pkg::REG_CHANNEL_COUNT:  count_nxt   = cfg_data[mptt_pkg::CHAN_W-1:0];
        mptt_pkg::REG_INITIAL_LEVELS: levels_nxt  = LW'(cfg_data);
        mptt_pkg::REG_DEFAULT_PULSE:  default_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign run_pad = LW'(running_nxt);

  // output register valid
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= mptt_pkg::COUNT_RESET;
      default_r   <= mptt_pkg::DEFAULT_PULSE_RESET;
      levels_r    <= LW'(mptt_pkg::INITIAL_LEVELS_RESET);
      running_r   <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      default_r   <= default_nxt;
      levels_r    <= levels_nxt;
      running_r   <= running_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    stg_idx_r <= stg_idx_nxt;
    elapsed_r <= elapsed_nxt;
  end

  // result word
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r  <= res_status;
      out_echo_r    <= res_echo;
      out_level_r   <= res_level;
      out_len_r     <= res_len;
      out_levels_r  <= levels_nxt[mptt_pkg::BANK_W-1:0];
      out_running_r <= run_pad[mptt_pkg::BANK_W-1:0];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.channel_echo = out_echo_r;
  assign out_if.level        = out_level_r;
  assign out_if.pulse_len    = out_len_r;
  assign out_if.levels       = out_levels_r;
  assign out_if.running_mask = out_running_r;

  // no new word during a tick walk
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> !in_if.ready)
    else $error("command accepted during tick walk");

  // walk index stays inside the live channels
  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (32'(stg_idx_r) < 32'(live_n)))
    else $error("tick walk index beyond channel count");

  // non-tick words answer in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_if.action != mptt_pkg::ACT_TICK)) |=> out_valid_r)
    else $error("result missing after command");

  // RAM writes only from a trigger or the tick walk
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_TICK) || acc))
    else $error("unexpected countdown write");

endmodule

// File: design/mptt_ram.sv
// ----------------------------------------------------------------------------
// mptt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mptt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: test/multi_channel_pulse_toggle_timer_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_toggle_timer_tb
// Self-checking bench for the pulse/toggle timer bank. Commands are fed from
// a queue through a valid/ready driver with random sender and receiver stalls.
// A behavioral copy of the channel bank predicts every result word, and the
// monitor checks each returned word against the oldest prediction. The run
// steps through several register settings, writing them only while idle.
// ----------------------------------------------------------------------------
module multi_channel_pulse_toggle_timer_tb;

  localparam int NCH = 16;

  typedef struct packed {
    mptt_pkg::action_t action;
    mptt_pkg::chan_t   channel;
    logic              invert;
    mptt_pkg::ms_t     pulse_ms;
    mptt_pkg::ms_t     elapsed_ms;
  } cmd_t;

  typedef struct packed {
    mptt_pkg::status_t status;
    mptt_pkg::chan_t   echo;
    logic              level;
    mptt_pkg::ms_t     pulse_len;
    mptt_pkg::bank_t   levels;
    mptt_pkg::bank_t   running;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  mptt_pkg::cfg_idx_t  cfg_index;
  mptt_pkg::cfg_data_t cfg_data;

  mptt_in_if  in_if();
  mptt_out_if out_if();

  multi_channel_pulse_toggle_timer #(.CHANNELS(NCH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the bank and its registers
  mptt_pkg::bank_t bank_lvls;
  mptt_pkg::ms_t   countdown [NCH];
  mptt_pkg::chan_t count_reg;
  mptt_pkg::ms_t   dflt_len;

  cmd_t    cmd_q [$];
  result_t want_q [$];
  int      errs;
  logic    in_took;
  logic    calm;
  int      snd_gap;
  int      rcv_gap;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predicted effect of one command word on the bank
  function automatic result_t timer_step(input cmd_t c);
    result_t r;
    int      n;
    int      idx;
    r = '0;
    n = (int'(count_reg) < NCH) ? int'(count_reg) : NCH;
    case (c.action)
      mptt_pkg::ACT_TRIGGER, mptt_pkg::ACT_TOGGLE: begin
        r.echo = c.channel;
        if (c.channel == 0) begin
          r.status = mptt_pkg::ST_NO_CHAN;
        end else if (int'(c.channel) > n) begin
          r.status = mptt_pkg::ST_BEYOND;
        end else if (countdown[c.channel - 1] != 0) begin
          r.status = mptt_pkg::ST_RUNNING;
        end else begin
          idx = int'(c.channel) - 1;
          if (c.action == mptt_pkg::ACT_TRIGGER) begin
            r.level = ~c.invert;
            bank_lvls[idx] = r.level;
            r.pulse_len = (c.pulse_ms != 0) ? c.pulse_ms : dflt_len;
            countdown[idx] = r.pulse_len;
          end else begin
            bank_lvls[idx] = ~bank_lvls[idx];
            r.level = bank_lvls[idx];
          end
        end
      end
      mptt_pkg::ACT_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          if (countdown[i] != 0) begin
            bank_lvls[i] = ~bank_lvls[i];
            countdown[i] = '0;
          end
        end
      end
      mptt_pkg::ACT_TICK: begin
        // expiry when the remaining time fits within the elapsed time
        for (int i = 0; i < n; i++) begin
          if (countdown[i] != 0) begin
            if (countdown[i] <= c.elapsed_ms) begin
              countdown[i] = '0;
              bank_lvls[i] = ~bank_lvls[i];
            end else begin
              countdown[i] = countdown[i] - c.elapsed_ms;
            end
          end
        end
      end
      default: ;
    endcase
    r.levels = bank_lvls;
    for (int i = 0; i < NCH; i++) r.running[i] = (countdown[i] != 0);
    return r;
  endfunction

  function automatic cmd_t mk(input mptt_pkg::action_t a, input int ch, input logic inv,
                              input int len, input int el);
    cmd_t c;
    c.action     = a;
    c.channel    = mptt_pkg::chan_t'(ch);
    c.invert     = inv;
    c.pulse_ms   = mptt_pkg::ms_t'(len);
    c.elapsed_ms = mptt_pkg::ms_t'(el);
    return c;
  endfunction

  // mostly well-formed traffic on live channels, with some raw noise
  function automatic cmd_t pick_cmd(input int n_live);
    cmd_t c;
    int   roll;
    c.action     = mptt_pkg::ACT_STATUS;
    c.channel    = mptt_pkg::chan_t'($urandom_range(0, NCH));
    c.invert     = 1'($urandom);
    c.pulse_ms   = mptt_pkg::ms_t'($urandom);
    c.elapsed_ms = mptt_pkg::ms_t'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      c.action = mptt_pkg::action_t'($urandom_range(0, 4));
    end else begin
      if (roll < 45)      c.action = mptt_pkg::ACT_TRIGGER;
      else if (roll < 58) c.action = mptt_pkg::ACT_TOGGLE;
      else if (roll < 88) c.action = mptt_pkg::ACT_TICK;
      else if (roll < 93) c.action = mptt_pkg::ACT_CLEAR;
      else                c.action = mptt_pkg::ACT_STATUS;
      if (n_live > 0 && $urandom_range(0, 9) != 0)
        c.channel = mptt_pkg::chan_t'($urandom_range(1, n_live));
      if ($urandom_range(0, 7) != 0)
        c.pulse_ms = mptt_pkg::ms_t'($urandom_range(0, 300));
      if ($urandom_range(0, 7) != 0)
        c.elapsed_ms = mptt_pkg::ms_t'($urandom_range(0, 120));
    end
    return c;
  endfunction

  task automatic add_random(input int cnt, input int n_live);
    for (int i = 0; i < cnt; i++) cmd_q.push_back(pick_cmd(n_live));
  endtask

  // register write while the bank is idle; shadow copy follows it
  task automatic write_reg(input mptt_pkg::cfg_idx_t idx, input mptt_pkg::cfg_data_t val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mptt_pkg::REG_CHANNEL_COUNT:  count_reg = mptt_pkg::chan_t'(val);
      mptt_pkg::REG_INITIAL_LEVELS: bank_lvls = mptt_pkg::bank_t'(val);
      mptt_pkg::REG_DEFAULT_PULSE:  dflt_len  = mptt_pkg::ms_t'(val);
      default: ;
    endcase
  endtask

  // hold until every queued word is sent and answered, then let a tick walk finish
  task automatic drain;
    while (cmd_q.size() != 0 || in_if.valid || want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic note_err(input string what, input result_t w, input result_t g);
    errs++;
    if (errs <= 10) begin
      $write("%s: want st=%0d ch=%0d lvl=%0d len=%0d lv=%h run=%h",
             what, w.status, w.echo, w.level, w.pulse_len, w.levels, w.running);
      $display(" | got st=%0d ch=%0d lvl=%0d len=%0d lv=%h run=%h",
               g.status, g.echo, g.level, g.pulse_len, g.levels, g.running);
    end
  endtask

  // command driver
  always @(negedge clk) begin
    cmd_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      // word still waiting for ready
    end else if (snd_gap > 0) begin
      snd_gap     <= snd_gap - 1;
      in_if.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snd_gap     <= $urandom_range(1, 18) - 1;
      in_if.valid <= 1'b0;
    end else if (cmd_q.size() != 0) begin
      nxt = cmd_q.pop_front();
      in_if.action     <= nxt.action;
      in_if.channel    <= nxt.channel;
      in_if.invert     <= nxt.invert;
      in_if.pulse_ms   <= nxt.pulse_ms;
      in_if.elapsed_ms <= nxt.elapsed_ms;
      in_if.valid      <= 1'b1;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result ready with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap      <= rcv_gap - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rcv_gap      <= $urandom_range(1, 18) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin
    cmd_t    c;
    result_t w;
    result_t g;
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      g.status    = out_if.status;
      g.echo      = out_if.channel_echo;
      g.level     = out_if.level;
      g.pulse_len = out_if.pulse_len;
      g.levels    = out_if.levels;
      g.running   = out_if.running_mask;
      if (want_q.size() == 0) begin
        note_err("unexpected word", '0, g);
      end else begin
        w = want_q.pop_front();
        if (g.status !== w.status || g.echo !== w.echo || g.level !== w.level ||
            g.pulse_len !== w.pulse_len || g.levels !== w.levels ||
            g.running !== w.running)
          note_err("mismatch", w, g);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      c.action     = in_if.action;
      c.channel    = in_if.channel;
      c.invert     = in_if.invert;
      c.pulse_ms   = in_if.pulse_ms;
      c.elapsed_ms = in_if.elapsed_ms;
      want_q.push_back(timer_step(c));
    end
  end

  // run limit
  initial begin
    #(12 * 1000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus sequence
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = mptt_pkg::REG_CHANNEL_COUNT;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.action     = mptt_pkg::ACT_STATUS;
    in_if.channel    = '0;
    in_if.invert     = 1'b0;
    in_if.pulse_ms   = '0;
    in_if.elapsed_ms = '0;
    out_if.ready     = 1'b0;
    in_took          = 1'b0;
    calm             = 1'b0;
    snd_gap          = 0;
    rcv_gap          = 0;
    errs             = 0;
    count_reg        = mptt_pkg::COUNT_RESET;
    bank_lvls        = mptt_pkg::INITIAL_LEVELS_RESET;
    dflt_len         = mptt_pkg::DEFAULT_PULSE_RESET;
    for (int i = 0; i < NCH; i++) countdown[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: refusals, default length, exact expiry, clear, wide fields
    cmd_q.push_back(mk(mptt_pkg::ACT_STATUS,  0, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 0, 1'b0, 5, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TOGGLE,  0, 1'b1, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 1, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 1, 1'b1, 9, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TOGGLE,  1, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 16, 1'b1, 65535, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TOGGLE,  2, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TOGGLE,  2, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TICK,    0, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TICK,    0, 1'b0, 0, 199));
    cmd_q.push_back(mk(mptt_pkg::ACT_TICK,    0, 1'b0, 0, 1));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 3, 1'b0, 1, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TICK,    31, 1'b1, 65535, 65535));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 5, 1'b0, 100, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 6, 1'b1, 50, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_CLEAR,   0, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_CLEAR,   0, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TRIGGER, 4, 1'b0, 65535, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_TICK,    0, 1'b0, 0, 65535));
    cmd_q.push_back(mk(mptt_pkg::ACT_TOGGLE,  16, 1'b0, 0, 0));
    cmd_q.push_back(mk(mptt_pkg::ACT_STATUS,  16, 1'b1, 65535, 65535));
    add_random(300, NCH);
    drain;

    // full bank, shortest default pulse
    write_reg(mptt_pkg::REG_CHANNEL_COUNT, 16);
    write_reg(mptt_pkg::REG_INITIAL_LEVELS, 16'hA5C3);
    write_reg(mptt_pkg::REG_DEFAULT_PULSE, 1);
    add_random(300, 16);
    drain;

    // single channel, longest default pulse; upper pulses stay frozen
    write_reg(mptt_pkg::REG_CHANNEL_COUNT, 1);
    write_reg(mptt_pkg::REG_INITIAL_LEVELS, 16'hFFFF);
    write_reg(mptt_pkg::REG_DEFAULT_PULSE, 16'hFFFF);
    add_random(250, 1);
    drain;

    // no channels in use: every nonzero channel refused as beyond the count
    write_reg(mptt_pkg::REG_CHANNEL_COUNT, 0);
    add_random(40, 0);
    drain;

    // partial bank, zero default pulse
    write_reg(mptt_pkg::REG_CHANNEL_COUNT, 7);
    write_reg(mptt_pkg::REG_INITIAL_LEVELS, 16'h5A3C);
    write_reg(mptt_pkg::REG_DEFAULT_PULSE, 0);
    add_random(300, 7);
    drain;

    // full bank again, random start levels, then a stall-free tail
    write_reg(mptt_pkg::REG_CHANNEL_COUNT, 16);
    write_reg(mptt_pkg::REG_INITIAL_LEVELS, mptt_pkg::cfg_data_t'($urandom));
    write_reg(mptt_pkg::REG_DEFAULT_PULSE, 37);
    add_random(350, 16);
    while (cmd_q.size() != 0) @(posedge clk);
    calm = 1'b1;
    add_random(150, 16);
    drain;

    if (want_q.size() != 0) errs++;
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
